// ----- design/sorted_matrix_staircase_search_macros.svh -----
// ----------------------------------------------------------------------------
// Sorted matrix staircase search - assertion macros
// Shared concurrent assertion shorthands, clocked on clk_i, off during reset.
// ----------------------------------------------------------------------------
`ifndef SORTED_MATRIX_STAIRCASE_SEARCH_MACROS_SVH
`define SORTED_MATRIX_STAIRCASE_SEARCH_MACROS_SVH

// Same-cycle implication
`define SMSS_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication
`define SMSS_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- design/smss_pkg.sv -----
// ----------------------------------------------------------------------------
// smss_pkg
// Sizes, codes and shared types of the sorted matrix staircase search.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package smss_pkg;

  // Matrix geometry and element width
  localparam int unsigned MAX_ROWS   = 256;
  localparam int unsigned MAX_COLS   = 256;
  localparam int unsigned DATA_WIDTH = 32;

  // Index widths (at least one bit even for a single row or column)
  localparam int unsigned ROW_AW = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
  localparam int unsigned COL_AW = (MAX_COLS > 1) ? $clog2(MAX_COLS) : 1;
  localparam int unsigned ADDR_W = ROW_AW + COL_AW;
  // Counts 0..MAX inclusive
  localparam int unsigned ROW_DW = ROW_AW + 1;
  localparam int unsigned COL_DW = COL_AW + 1;
  // Signed column position: holds -1 and gallop overshoot down to -2*MAX_COLS
  localparam int unsigned COL_SW = COL_AW + 2;

  localparam logic signed [COL_SW-1:0] SCOL_ONE = COL_SW'(1);

  // Request codes
  localparam logic REQ_WRITE  = 1'b0;
  localparam logic REQ_SEARCH = 1'b1;

  // Configuration register indexes
  localparam logic CFG_ROWS_USED = 1'b0;
  localparam logic CFG_COLS_USED = 1'b1;

  // Search sequencer states
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_CORNER,
    ST_GALLOP,
    ST_BIN,
    ST_DONE
  } smss_state_e;

  // Element memory ports
  typedef struct packed {
    logic                  en;
    logic [ADDR_W-1:0]     addr;
    logic [DATA_WIDTH-1:0] data;
  } smss_wr_t;

  typedef struct packed {
    logic              en;
    logic [ADDR_W-1:0] addr;
  } smss_rd_t;

endpackage

// ----- design/sorted_matrix_staircase_search.sv -----
// Write transaction: element stored at the edge that accepts it, no result.
// Search transaction: one element read per cycle, with
//   probes <= rows_used * (2 + 2*ceil(log2(cols_used))).
// One transaction in flight: the next transaction is accepted only after a search has loaded
//   its result into the output register, later while a stalled result still holds that register.
// Reset: rows_used and cols_used return to 256; the element store is not cleared.
// ----------------------------------------------------------------------------
// sorted_matrix_staircase_search
// Membership search over a row- and column-sorted matrix held in on-chip memory.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module sorted_matrix_staircase_search (
  input  logic               clk_i,
  input  logic               rst_ni,
  // configuration write port
  input  logic               cfg_we_i,
  input  logic               cfg_idx_i,
  input  logic [8:0]         cfg_wdata_i,
  // request channel
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  logic               req_type_i,
  input  logic [7:0]         row_index_i,
  input  logic [7:0]         col_index_i,
  input  logic signed [31:0] item_value_i,
  // result channel
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output logic               found_o
);
  import smss_pkg::*;

  logic [8:0]            rows_used_q, cols_used_q;
  logic [ROW_DW-1:0]     m_clamp;
  logic [COL_DW-1:0]     n_clamp;
  smss_wr_t              wr;
  smss_rd_t              rd;
  logic [DATA_WIDTH-1:0] rd_data;

  // Configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rows_used_q <= 9'd256;
      cols_used_q <= 9'd256;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CFG_ROWS_USED: rows_used_q <= cfg_wdata_i;
        CFG_COLS_USED: cols_used_q <= cfg_wdata_i;
        default: begin
        end
      endcase
    end
  end

  // Sizes above the array act as the array size
  assign m_clamp = (16'(rows_used_q) > 16'(MAX_ROWS)) ? ROW_DW'(MAX_ROWS)
                                                      : ROW_DW'(rows_used_q);
  assign n_clamp = (16'(cols_used_q) > 16'(MAX_COLS)) ? COL_DW'(MAX_COLS)
                                                      : COL_DW'(cols_used_q);

  smss_ctrl u_ctrl (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_ready_o   (in_ready_o),
    .req_type_i   (req_type_i),
    .row_index_i  (row_index_i),
    .col_index_i  (col_index_i),
    .item_value_i (item_value_i),
    .out_valid_o  (out_valid_o),
    .out_ready_i  (out_ready_i),
    .found_o      (found_o),
    .m_i          (m_clamp),
    .n_i          (n_clamp),
    .wr_o         (wr),
    .rd_o         (rd),
    .rd_data_i    (rd_data)
  );

  smss_mem u_mem (
    .clk_i     (clk_i),
    .wr_i      (wr),
    .rd_i      (rd),
    .rd_data_o (rd_data)
  );

endmodule

// ----- design/smss_mem.sv -----
// ----------------------------------------------------------------------------
// smss_mem
// Element store: one write port, one read port, registered read data.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module smss_mem (
  input  logic                             clk_i,
  input  smss_pkg::smss_wr_t               wr_i,
  input  smss_pkg::smss_rd_t               rd_i,
  output logic [smss_pkg::DATA_WIDTH-1:0]  rd_data_o
);
  import smss_pkg::*;

  localparam int unsigned DEPTH = 2 ** ADDR_W;

  logic [DATA_WIDTH-1:0] mem_q [DEPTH];
  logic [DATA_WIDTH-1:0] rd_data_q;

  // Row-major {row, col} addressing, registered read data
  always_ff @(posedge clk_i) begin
    if (wr_i.en) begin
      mem_q[wr_i.addr] <= wr_i.data;
    end
    if (rd_i.en) begin
      rd_data_q <= mem_q[rd_i.addr];
    end
  end

  assign rd_data_o = rd_data_q;

endmodule

// ----- design/smss_ctrl.sv -----
// ----------------------------------------------------------------------------
// smss_ctrl
// Transaction front end and search sequencer: corner probe, gallop, binary
// search per row, result register.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module smss_ctrl (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  // request channel
  input  logic                            in_valid_i,
  output logic                            in_ready_o,
  input  logic                            req_type_i,
  input  logic [7:0]                      row_index_i,
  input  logic [7:0]                      col_index_i,
  input  logic signed [31:0]              item_value_i,
  // result channel
  output logic                            out_valid_o,
  input  logic                            out_ready_i,
  output logic                            found_o,
  // clamped matrix size
  input  logic [smss_pkg::ROW_DW-1:0]     m_i,
  input  logic [smss_pkg::COL_DW-1:0]     n_i,
  // element memory
  output smss_pkg::smss_wr_t              wr_o,
  output smss_pkg::smss_rd_t              rd_o,
  input  logic [smss_pkg::DATA_WIDTH-1:0] rd_data_i
);
  import smss_pkg::*;

  smss_state_e state_q, state_d;

  logic [ROW_DW-1:0]            i_q, i_d;
  logic signed [COL_SW-1:0]     j_q, j_d;
  logic signed [COL_SW-1:0]     step_q, step_d;
  logic signed [COL_SW-1:0]     lo_q, lo_d;
  logic signed [COL_SW-1:0]     hi_q, hi_d;
  logic signed [COL_SW-1:0]     mid_q, mid_d;
  logic signed [DATA_WIDTH-1:0] target_q, target_d;
  logic                         res_q, res_d;
  logic                         out_valid_q, out_valid_d;
  logic                         found_q;

  logic                         in_fire;
  logic                         go_corner, go_gallop, go_bin, go_done;
  logic                         out_load;
  logic [ROW_AW-1:0]            rd_row;
  logic [COL_AW-1:0]            rd_col;

  logic signed [63:0]           item_ext;
  logic [DATA_WIDTH-1:0]        item_val;
  logic signed [DATA_WIDTH-1:0] elem;
  logic                         elem_eq, elem_lt;
  logic [15:0]                  wr_row, wr_col;

  // Value normalization: sign-extend, keep the low DATA_WIDTH bits
  assign item_ext = 64'(item_value_i);
  assign item_val = item_ext[DATA_WIDTH-1:0];

  assign elem    = $signed(rd_data_i);
  assign elem_eq = (elem == target_q);
  assign elem_lt = (elem < target_q);

  assign in_fire = in_valid_i && in_ready_o;

  assign wr_row = 16'(row_index_i);
  assign wr_col = 16'(col_index_i);

  // Search datapath: probe decisions and next index values
  always_comb begin
    logic [ROW_DW-1:0]        ii;
    logic signed [COL_SW-1:0] jj, st, jm, lo_n, hi_n, mid_n;
    logic                     do_top, do_end, do_bin;

    i_d      = i_q;
    j_d      = j_q;
    step_d   = step_q;
    lo_d     = lo_q;
    hi_d     = hi_q;
    mid_d    = mid_q;
    target_d = target_q;
    res_d    = res_q;

    go_corner = 1'b0;
    go_gallop = 1'b0;
    go_bin    = 1'b0;
    go_done   = 1'b0;
    rd_row    = i_q[ROW_AW-1:0];
    rd_col    = j_q[COL_AW-1:0];

    ii     = i_q;
    jj     = j_q;
    st     = step_q;
    jm     = j_q;
    lo_n   = lo_q;
    hi_n   = hi_q;
    mid_n  = mid_q;
    do_top = 1'b0;
    do_end = 1'b0;
    do_bin = 1'b0;

    unique case (state_q)
      ST_IDLE: begin
        if (in_fire && (req_type_i == REQ_SEARCH)) begin
          target_d = $signed(item_val);
          ii       = '0;
          jj       = $signed({1'b0, n_i}) - SCOL_ONE;
          do_top   = 1'b1;
        end
      end
      ST_CORNER: begin
        if (elem_eq) begin
          res_d   = 1'b1;
          go_done = 1'b1;
        end else if (elem_lt) begin
          ii     = i_q + ROW_DW'(1);
          jj     = j_q;
          do_top = 1'b1;
        end else begin
          // Start the gallop one column to the left
          jm = j_q - SCOL_ONE;
          if (!jm[COL_SW-1]) begin
            step_d    = SCOL_ONE;
            go_gallop = 1'b1;
            rd_col    = jm[COL_AW-1:0];
          end else begin
            st     = SCOL_ONE;
            do_end = 1'b1;
          end
        end
      end
      ST_GALLOP: begin
        if (!elem_lt && !elem_eq) begin
          st = step_q <<< 1;
          jm = j_q - st;
          if (!jm[COL_SW-1]) begin
            step_d    = st;
            go_gallop = 1'b1;
            rd_col    = jm[COL_AW-1:0];
          end else begin
            do_end = 1'b1;
          end
        end else begin
          st     = step_q;
          do_end = 1'b1;
        end
      end
      ST_BIN: begin
        if (elem_eq) begin
          res_d   = 1'b1;
          go_done = 1'b1;
        end else begin
          if (elem_lt) begin
            lo_n = mid_q + SCOL_ONE;
            hi_n = hi_q;
          end else begin
            lo_n = lo_q;
            hi_n = mid_q - SCOL_ONE;
          end
          if (lo_n <= hi_n) begin
            do_bin = 1'b1;
          end else begin
            // Miss: next row, resume at the last column below the target
            ii     = i_q + ROW_DW'(1);
            jj     = hi_n;
            do_top = 1'b1;
          end
        end
      end
      ST_DONE: begin
      end
      default: begin
      end
    endcase

    // Gallop finished: bracket the span [max(j-step,0), j-step/2]
    if (do_end) begin
      jm     = j_q - st;
      lo_n   = jm[COL_SW-1] ? '0 : jm;
      hi_n   = j_q - (st >>> 1);
      do_bin = 1'b1;
    end

    // Binary search probe at the span middle
    if (do_bin) begin
      mid_n  = lo_n + ((hi_n - lo_n) >>> 1);
      lo_d   = lo_n;
      hi_d   = hi_n;
      mid_d  = mid_n;
      go_bin = 1'b1;
      rd_col = mid_n[COL_AW-1:0];
    end

    // Staircase step: probe (ii, jj) if still inside the used part
    if (do_top) begin
      i_d = ii;
      j_d = jj;
      if ((ii < m_i) && !jj[COL_SW-1]) begin
        go_corner = 1'b1;
        rd_row    = ii[ROW_AW-1:0];
        rd_col    = jj[COL_AW-1:0];
      end else begin
        res_d   = 1'b0;
        go_done = 1'b1;
      end
    end
  end

  // Next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE, ST_CORNER, ST_GALLOP, ST_BIN: begin
        priority if (go_done) begin
          state_d = ST_DONE;
        end else if (go_corner) begin
          state_d = ST_CORNER;
        end else if (go_gallop) begin
          state_d = ST_GALLOP;
        end else if (go_bin) begin
          state_d = ST_BIN;
        end
      end
      ST_DONE: begin
        if (out_load) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // Outputs: handshakes and memory requests
  always_comb begin
    in_ready_o = (state_q == ST_IDLE);
    out_load   = (state_q == ST_DONE) && (!out_valid_q || out_ready_i);

    rd_o.en   = go_corner || go_gallop || go_bin;
    rd_o.addr = {rd_row, rd_col};

    wr_o.en   = in_fire && (req_type_i == REQ_WRITE) &&
                (wr_row < 16'(MAX_ROWS)) && (wr_col < 16'(MAX_COLS));
    wr_o.addr = {wr_row[ROW_AW-1:0], wr_col[COL_AW-1:0]};
    wr_o.data = item_val;

    out_valid_d = out_valid_q;
    if (out_load) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  // Control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Search registers and result payload
  always_ff @(posedge clk_i) begin
    i_q      <= i_d;
    j_q      <= j_d;
    step_q   <= step_d;
    lo_q     <= lo_d;
    hi_q     <= hi_d;
    mid_q    <= mid_d;
    target_q <= target_d;
    res_q    <= res_d;
    if (out_load) begin
      found_q <= res_q;
    end
  end

  assign out_valid_o = out_valid_q;
  assign found_o     = found_q;

`include "sorted_matrix_staircase_search_macros.svh"

  // Every issued read leads into a probe state
  `SMSS_ASSERT_NXT(a_probe_read, rd_o.en, state_q == ST_CORNER || state_q == ST_GALLOP || state_q == ST_BIN, "read issued without probe state")
  // Probes stay inside the used rows
  `SMSS_ASSERT_IMP(a_row_bound, state_q == ST_CORNER || state_q == ST_GALLOP || state_q == ST_BIN, i_q < m_i, "probe row out of range")
  // Gallop probe column is never left of column zero
  `SMSS_ASSERT_IMP(a_gallop_col, state_q == ST_GALLOP, (j_q - step_q) >= 0, "gallop column negative")
  // Binary search only runs on a nonempty span
  `SMSS_ASSERT_IMP(a_bin_span, state_q == ST_BIN, lo_q <= hi_q && lo_q <= mid_q && mid_q <= hi_q, "binary span broken")

endmodule
